### rtl/core/dwpm_pkg.sv
package dwpm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_DIM   = 4096;
   localparam int SAT_SHIFT = 14;
   localparam int DIV_W     = 34;
   localparam int QUO_W     = 30;
   localparam int REM_W     = DIV_W + FRAC_BITS;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SIN    = 2'd2;
   localparam logic [1:0] CSR_COS    = 2'd3;

   localparam logic [12:0]        RST_WIDTH  = 13'd320;
   localparam logic [12:0]        RST_HEIGHT = 13'd200;
   localparam logic [16:0]        RST_SIN    = 17'd46341;
   localparam logic signed [17:0] RST_COS    = -18'sd46341;

   typedef struct packed {
      logic [11:0] dest_x;
      logic [11:0] dest_y;
   } req_payload_type;

   typedef struct packed {
      logic        from_end;
      logic [11:0] src_x;
      logic [11:0] src_y;
   } rsp_payload_type;

   typedef struct packed {
      logic [12:0]        screen_width;
      logic [12:0]        screen_height;
      logic [16:0]        sin_value;
      logic signed [17:0] cos_value;
   } cfg_type;

   typedef struct packed {
      logic                    ok;
      logic                    right;
      logic [11:0]             dest_y;
      logic signed [DIV_W-1:0] num_r;
      logic signed [DIV_W-1:0] num_s;
      logic signed [DIV_W-1:0] den;
   } front_type;

   typedef struct packed {
      logic signed [31:0] quot;
      logic [DIV_W-1:0]   rem;
   } div_res_type;

   typedef struct packed {
      logic ok;
      logic right;
   } rside_type;

   typedef struct packed {
      logic               ok;
      logic [11:0]        src_x;
      logic signed [31:0] scale;
      logic [11:0]        dest_y;
   } hside_type;

endpackage

### rtl/core/dwpm_front.sv
module dwpm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  dwpm_pkg::req_payload_type in_data,
   input  dwpm_pkg::cfg_type         cfg,
   output logic                      out_valid,
   output dwpm_pkg::front_type       out_data
);
   import dwpm_pkg::*;

   logic [11:0] half;
   logic [12:0] wmh;
   logic        outside, left, rgt;
   logic [11:0] col;

   logic        f1_valid_ff, f1_ok_ff, f1_right_ff;
   logic [11:0] f1_dy_ff, f1_col_ff;
   logic [12:0] f1_hmc_ff;

   logic               f2_valid_ff, f2_ok_ff, f2_right_ff;
   logic [11:0]        f2_dy_ff;
   logic [29:0]        p1_in, f2_p1_ff;
   logic signed [30:0] p2_in, f2_p2_ff;
   logic [23:0]        hc_in, f2_hc_ff;
   logic signed [18:0] cs_sum;
   logic signed [31:0] ns_in, f2_ns_ff;

   logic               f3_valid_ff;
   front_type          f3_in, f3_ff;
   logic signed [31:0] den_w;

   assign half = cfg.screen_width[12:1];
   assign wmh  = cfg.screen_width - {1'b0, half};

   always_comb begin
      outside = ({1'b0, in_data.dest_x} >= cfg.screen_width)
             || ({1'b0, in_data.dest_y} >= cfg.screen_height)
             || (32'(in_data.dest_x) >= MAX_DIM)
             || (32'(in_data.dest_y) >= MAX_DIM);
      left = in_data.dest_x < half;
      rgt  = {1'b0, in_data.dest_x} >= wmh;
      col  = left ? in_data.dest_x
                  : 12'(cfg.screen_width - 13'd1 - {1'b0, in_data.dest_x});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ok_ff    <= !outside && (left || rgt);
         f1_right_ff <= !left;
         f1_dy_ff    <= in_data.dest_y;
         f1_col_ff   <= col;
         f1_hmc_ff   <= {1'b0, half} - {1'b0, col};
      end
   end

   always_comb begin
      p1_in  = f1_hmc_ff * cfg.sin_value;
      p2_in  = $signed({1'b0, half}) * cfg.cos_value;
      hc_in  = half * f1_col_ff;
      cs_sum = $signed({2'b00, cfg.sin_value}) + $signed({cfg.cos_value[17], cfg.cos_value});
      ns_in  = $signed({1'b0, half}) * cs_sum;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_ok_ff    <= f1_ok_ff;
         f2_right_ff <= f1_right_ff;
         f2_dy_ff    <= f1_dy_ff;
         f2_p1_ff    <= p1_in;
         f2_p2_ff    <= p2_in;
         f2_hc_ff    <= hc_in;
         f2_ns_ff    <= ns_in;
      end
   end

   always_comb begin
      den_w        = $signed({2'b00, f2_p1_ff}) + 32'(f2_p2_ff);
      f3_in.ok     = f2_ok_ff;
      f3_in.right  = f2_right_ff;
      f3_in.dest_y = f2_dy_ff;
      f3_in.num_r  = $signed(DIV_W'({f2_hc_ff, 1'b0}));
      f3_in.num_s  = DIV_W'(f2_ns_ff);
      f3_in.den    = DIV_W'(den_w);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f3_ff <= f3_in;
      end
   end

   assign out_valid = f3_valid_ff;
   assign out_data  = f3_ff;

endmodule

### rtl/core/dwpm_div.sv
module dwpm_div #(
   parameter int SIDE_W = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [dwpm_pkg::DIV_W-1:0]    num,
   input  logic signed [dwpm_pkg::DIV_W-1:0]    den,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   output dwpm_pkg::div_res_type                out_res,
   output logic [SIDE_W-1:0]                    out_side
);
   import dwpm_pkg::*;

   typedef struct packed {
      logic             sat;
      logic             neg;
      logic [DIV_W-1:0] dvs;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } stage_type;

   stage_type         stage_in [0:QUO_W];
   stage_type         stage_ff [0:QUO_W];
   logic              valid_ff [0:QUO_W];
   logic [SIDE_W-1:0] side_ff  [0:QUO_W];
   logic [DIV_W-1:0]  num_abs, den_abs;
   stage_type         last;

   always_comb begin
      num_abs = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
      den_abs = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
      stage_in[0].sat = (num_abs >> SAT_SHIFT) >= den_abs;
      stage_in[0].neg = num[DIV_W-1] ^ den[DIV_W-1];
      stage_in[0].dvs = den_abs;
      stage_in[0].rem = {num_abs, {FRAC_BITS{1'b0}}};
      stage_in[0].quo = '0;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [REM_W-1:0] hi;
      logic             take;
      always_comb begin
         hi          = stage_ff[k-1].rem >> (QUO_W - k);
         take        = hi >= REM_W'(stage_ff[k-1].dvs);
         stage_in[k] = stage_ff[k-1];
         if (take) begin
            stage_in[k].rem = stage_ff[k-1].rem
                            - (REM_W'(stage_ff[k-1].dvs) << (QUO_W - k));
         end
         stage_in[k].quo[QUO_W-k] = take;
      end
   end

   for (genvar k = 0; k <= QUO_W; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= stage_in[k];
            side_ff[k]  <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_comb begin
      last = stage_ff[QUO_W];
      if (last.sat) begin
         out_res.quot = last.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (last.neg) begin
         out_res.quot = -$signed({2'b00, last.quo});
      end else begin
         out_res.quot = $signed({2'b00, last.quo});
      end
      out_res.rem = last.rem[DIV_W-1:0];
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

### rtl/core/dwpm_tail.sv
module dwpm_tail (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  dwpm_pkg::div_res_type     res,
   input  dwpm_pkg::hside_type       side,
   input  dwpm_pkg::cfg_type         cfg,
   output logic                      out_valid,
   output dwpm_pkg::rsp_payload_type out_data
);
   import dwpm_pkg::*;

   logic signed [33:0] v, vr, top, d;
   logic               hpos, inr;
   logic [29:0]        sh;

   logic        h1_valid_ff, h1_ok_ff;
   logic [11:0] h1_sx_ff;
   logic [30:0] h1_s_ff;
   logic [31:0] h1_d_ff;
   logic [29:0] h1_sh_ff;

   logic        h2_valid_ff, h2_ok_ff;
   logic [11:0] h2_sx_ff;
   logic [46:0] pp_lo_ff, pp_hi_ff;
   logic [29:0] base_ff;

   logic            h3_valid_ff;
   rsp_payload_type h3_in, h3_ff;
   logic [33:0]     pos;
   logic [17:0]     row, hm1;

   always_comb begin
      hpos = !res.quot[31] && (res.quot != 32'sd0);
      v    = $signed({21'b0, cfg.screen_height}) - 34'(res.quot);
      vr   = v + $signed({33'b0, v[33]});
      top  = vr >>> 1;
      d    = $signed({22'b0, side.dest_y}) - top;
      inr  = !d[33] && (d < 34'(res.quot));
      sh   = (side.scale == 32'sd0) ? 30'd0
           : 30'({cfg.screen_height, 16'b0}) - 30'(res.rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
         h3_valid_ff <= 1'b0;
      end else if (en) begin
         h1_valid_ff <= in_valid;
         h2_valid_ff <= h1_valid_ff;
         h3_valid_ff <= h2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ok_ff <= side.ok && hpos && inr;
         h1_sx_ff <= side.src_x;
         h1_s_ff  <= side.scale[30:0];
         h1_d_ff  <= d[31:0];
         h1_sh_ff <= sh;
         h2_ok_ff <= h1_ok_ff;
         h2_sx_ff <= h1_sx_ff;
         pp_lo_ff <= h1_s_ff * h1_d_ff[15:0];
         pp_hi_ff <= h1_s_ff * h1_d_ff[31:16];
         base_ff  <= 30'({cfg.screen_height, 15'b0}) - {1'b0, h1_sh_ff[29:1]};
      end
   end

   always_comb begin
      pos = 34'(pp_lo_ff) + {pp_hi_ff[17:0], 16'b0} + 34'(base_ff);
      row = pos[33:16];
      hm1 = 18'(cfg.screen_height - 13'd1);
      if (row > hm1) begin
         row = hm1;
      end
      h3_in.from_end = h2_ok_ff;
      h3_in.src_x    = h2_ok_ff ? h2_sx_ff : 12'd0;
      h3_in.src_y    = h2_ok_ff ? row[11:0] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h3_ff <= h3_in;
      end
   end

   assign out_valid = h3_valid_ff;
   assign out_data  = h3_ff;

endmodule

### rtl/core/door_wipe_perspective_mapper_unit.sv
// channel  | ports                                  | role
// req      | req_valid, req_ready, req_data         | destination pixel (dest_x, dest_y)
// rsp      | rsp_valid, rsp_ready, rsp_data         | from_end, src_x, src_y
// csr      | csr_we, csr_index, csr_wdata           | width, height, sin, cos writes
//
// One beat per clock sustained while the skid is empty; register stages in order: front 3,
// column dividers 31, rounding 1, height divider 31, row math 3, output 1.
// The three 30-step restoring dividers, one quotient bit per step, set the depth.
// Synchronous reset clears valid bits and loads the register defaults.
// A stalled output fills a one-beat skid; req_ready drops only while it is full.
module door_wipe_perspective_mapper_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dwpm_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dwpm_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [17:0]               csr_wdata
);
   import dwpm_pkg::*;

   cfg_type cfg_ff;
   logic    en;

   logic      f_valid;
   front_type f_data;

   logic        r_valid, s_valid;
   div_res_type r_res, s_res;
   rside_type   r_side_in, r_side;
   logic [11:0] s_side;

   logic [11:0]        half;
   logic signed [32:0] t, rr;
   logic               ok2;
   logic [11:0]        sx;
   logic               g1_valid_ff;
   hside_type          g1_in, g1_ff;

   logic        h_valid;
   div_res_type h_res;
   hside_type   h_side;

   logic            t_valid;
   rsp_payload_type t_data;

   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_WIDTH;
         cfg_ff.screen_height <= RST_HEIGHT;
         cfg_ff.sin_value     <= RST_SIN;
         cfg_ff.cos_value     <= RST_COS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  cfg_ff.screen_width  <= csr_wdata[12:0];
            CSR_HEIGHT: cfg_ff.screen_height <= csr_wdata[12:0];
            CSR_SIN:    cfg_ff.sin_value     <= csr_wdata[16:0];
            CSR_COS:    cfg_ff.cos_value     <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   dwpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   assign r_side_in.ok    = f_data.ok;
   assign r_side_in.right = f_data.right;

   dwpm_div #(.SIDE_W($bits(rside_type))) u_div_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num       (f_data.num_r),
      .den       (f_data.den),
      .in_side   (r_side_in),
      .out_valid (r_valid),
      .out_res   (r_res),
      .out_side  (r_side)
   );

   dwpm_div #(.SIDE_W(12)) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num       (f_data.num_s),
      .den       (f_data.den),
      .in_side   (f_data.dest_y),
      .out_valid (s_valid),
      .out_res   (s_res),
      .out_side  (s_side)
   );

   // round (r + 1) / 2 toward zero, keep 0 <= r <= half
   always_comb begin
      half = cfg_ff.screen_width[12:1];
      t    = $signed({r_res.quot[31], r_res.quot}) + 33'sd1;
      rr   = (t + $signed({32'b0, t[32]})) >>> 1;
      ok2  = r_side.ok && !rr[32] && (rr <= $signed({21'b0, half}));
      sx   = r_side.right ? 12'(cfg_ff.screen_width - 13'd1 - rr[12:0]) : rr[11:0];
      g1_in.ok     = ok2;
      g1_in.src_x  = sx;
      g1_in.scale  = s_res.quot;
      g1_in.dest_y = s_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
      end else if (en) begin
         g1_valid_ff <= r_valid && s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff <= g1_in;
      end
   end

   dwpm_div #(.SIDE_W($bits(hside_type))) u_div_h (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g1_valid_ff),
      .num       ($signed(DIV_W'(cfg_ff.screen_height))),
      .den       (DIV_W'(g1_ff.scale)),
      .in_side   (g1_ff),
      .out_valid (h_valid),
      .out_res   (h_res),
      .out_side  (h_side)
   );

   dwpm_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid),
      .res       (h_res),
      .side      (h_side),
      .cfg       (cfg_ff),
      .out_valid (t_valid),
      .out_data  (t_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= t_valid;
      end else if (t_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_data_ff <= t_data;
      end else begin
         skid_data_ff <= t_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
